[src/ftpg_pkg.sv]
// Shared types, constants and CRC helpers for the frame tag payload generator.
`default_nettype none

package ftpg_pkg;

   localparam int FID_W   = 24;
   localparam int BLK_W   = 6;
   localparam int PHASE_W = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic       OP_FRAME   = 1'b0;
   localparam logic       OP_MEASURE = 1'b1;

   localparam logic [1:0] CSR_LAST_LINE   = 2'd0;
   localparam logic [1:0] CSR_TICK_BUDGET = 2'd1;
   localparam logic [1:0] CSR_SYNC        = 2'd2;

   localparam logic [7:0]  LAST_LINE_RST   = 8'd227;
   localparam logic [15:0] TICK_BUDGET_RST = 16'd1309;
   localparam logic [7:0]  SYNC_RST        = 8'hB2;

   localparam logic [7:0] CRC_POLY   = 8'h07;
   localparam logic [7:0] CRC_INIT   = 8'hFF;
   localparam logic [6:0] MARGIN_MAX = 7'h7F;
   localparam logic [5:0] BAR_WRAP   = 6'd31;
   localparam logic [5:0] BAR_STEP   = 6'd8;
   localparam logic [7:0] BAR_BASE_X = 8'd56;

   typedef struct packed {
      logic [7:0]  last_line;
      logic [15:0] tick_budget;
   } limits_type;

   typedef struct packed {
      logic [FID_W-1:0]   fid;
      logic [PHASE_W-1:0] phase;
      logic [PHASE_W-1:0] old_phase;
      logic [7:0]         status;
   } frame_type;

   typedef struct packed {
      logic [FID_W-1:0] fid;
      logic [BLK_W-1:0] blk;
      logic [7:0]       status;
      logic [7:0]       x_new;
      logic [7:0]       x_old;
      logic             last;
      logic [7:0]       crc;
   } blk_type;

   // MSB-first CRC-8 over eight data bits
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_i, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      c = crc_i;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ data[i];
         c  = {c[6:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // MSB-first CRC-8 over the six block index bits
   function automatic logic [7:0] crc8_blk(input logic [7:0] crc_i,
                                           input logic [BLK_W-1:0] data);
      logic [7:0] c;
      logic       fb;
      c = crc_i;
      for (int i = BLK_W-1; i >= 0; i--) begin
         fb = c[7] ^ data[i];
         c  = {c[6:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic logic [PHASE_W-1:0] phase_next(input logic [PHASE_W-1:0] p);
      logic [5:0] s;
      s = {1'b0, p} + BAR_STEP;
      if (s >= BAR_WRAP) begin
         s = s - BAR_WRAP;
      end
      return s[PHASE_W-1:0];
   endfunction

   function automatic logic [7:0] bar_x(input logic [PHASE_W-1:0] p);
      return BAR_BASE_X + {1'b0, p, 2'b00};
   endfunction

endpackage

`default_nettype wire

[src/ftpg_fifo.sv]
// Short frame queue between the front and back halves.
`default_nettype none

module ftpg_fifo
   import ftpg_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire frame_type push_data,
   input  wire logic      pop,
   output frame_type      pop_data,
   output logic           full,
   output logic           empty
);

   frame_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/ftpg_front.sv]
// Front half: takes transactions, updates the fault/margin status, queues frames.
`default_nettype none

module ftpg_front
   import ftpg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire limits_type         limits,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_operation,
   input  wire logic [FID_W-1:0]   req_frame_id,
   input  wire logic [PHASE_W-1:0] req_bar_phase,
   input  wire logic [PHASE_W-1:0] req_prev_bar_phase,
   input  wire logic [7:0]         req_line_start,
   input  wire logic [7:0]         req_line_end,
   input  wire logic [15:0]        req_elapsed_ticks,
   output logic                    q_push,
   output frame_type               q_data,
   input  wire logic               q_full
);

   logic       fault_ff, fault_in;
   logic [6:0] margin_ff, margin_in;
   logic       accept;
   logic       is_fault;
   logic [7:0] margin_raw;
   logic [6:0] margin_clamp;

   // measurements never need queue space
   assign req_ready = (req_operation == OP_MEASURE) || !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && (req_operation == OP_FRAME);

   assign q_data.fid       = req_frame_id;
   assign q_data.phase     = req_bar_phase;
   assign q_data.old_phase = req_prev_bar_phase;
   assign q_data.status    = {fault_ff, margin_ff};

   assign is_fault = (req_line_end < req_line_start) ||
                     (req_line_end > limits.last_line) ||
                     (req_elapsed_ticks > limits.tick_budget);
   assign margin_raw   = limits.last_line - req_line_end;
   assign margin_clamp = margin_raw[7] ? MARGIN_MAX : margin_raw[6:0];

   always_comb begin
      fault_in  = fault_ff;
      margin_in = margin_ff;
      if (accept && (req_operation == OP_MEASURE)) begin
         if (is_fault) begin
            fault_in  = 1'b1;
            margin_in = '0;
         end else if (margin_clamp < margin_ff) begin
            margin_in = margin_clamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff  <= 1'b0;
         margin_ff <= MARGIN_MAX;
      end else begin
         fault_ff  <= fault_in;
         margin_ff <= margin_in;
      end
   end

endmodule

`default_nettype wire

[src/ftpg_back.sv]
// Back half: walks the blocks of a queued frame through a CRC pipeline to the result port.
`default_nettype none

module ftpg_back
   import ftpg_pkg::*;
#(
   parameter int BLOCK_COUNT = 40
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        sync_pattern,
   input  wire logic              q_empty,
   input  wire frame_type         q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [BLK_W-1:0]       rsp_blk_num,
   output logic [53:0]            rsp_payload,
   output logic [7:0]             rsp_status_snapshot,
   output logic [7:0]             rsp_bar_x_new,
   output logic [7:0]             rsp_bar_x_old,
   output logic                   rsp_last_block
);

   localparam int NSTAGE = 5;
   localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCK_COUNT - 1);

   logic               busy_ff, busy_in;
   frame_type          cur_ff, cur_in;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [PHASE_W-1:0] prev_ff, prev_in;
   logic [NSTAGE-1:0]  vld_ff, vld_in;
   blk_type            st_ff [NSTAGE];
   blk_type            st_in [NSTAGE];
   logic               adv;
   logic               issue;
   logic               last_issue;

   // whole pipeline holds while the output transaction is stalled
   assign adv        = !vld_ff[NSTAGE-1] || rsp_ready;
   assign issue      = busy_ff && adv;
   assign last_issue = issue && (blk_ff == BLK_LAST);
   assign q_pop      = !q_empty && (!busy_ff || last_issue);

   always_comb begin
      busy_in  = busy_ff;
      cur_in   = cur_ff;
      blk_in   = blk_ff;
      phase_in = phase_ff;
      prev_in  = prev_ff;
      if (q_pop) begin
         busy_in  = 1'b1;
         cur_in   = q_data;
         blk_in   = '0;
         phase_in = q_data.phase;
         prev_in  = q_data.old_phase;
      end else if (last_issue) begin
         busy_in = 1'b0;
      end else if (issue) begin
         blk_in   = blk_ff + 1'b1;
         phase_in = phase_next(phase_ff);
         prev_in  = phase_next(prev_ff);
      end
   end

   always_comb begin
      st_in[0].fid    = cur_ff.fid;
      st_in[0].blk    = blk_ff;
      st_in[0].status = cur_ff.status;
      st_in[0].x_new  = bar_x(phase_ff);
      st_in[0].x_old  = bar_x(prev_ff);
      st_in[0].last   = (blk_ff == BLK_LAST);
      st_in[0].crc    = crc8_byte(CRC_INIT, cur_ff.fid[23:16]);
      st_in[1]        = st_ff[0];
      st_in[1].crc    = crc8_byte(st_ff[0].crc, st_ff[0].fid[15:8]);
      st_in[2]        = st_ff[1];
      st_in[2].crc    = crc8_byte(st_ff[1].crc, st_ff[1].fid[7:0]);
      st_in[3]        = st_ff[2];
      st_in[3].crc    = crc8_blk(st_ff[2].crc, st_ff[2].blk);
      st_in[4]        = st_ff[3];
      st_in[4].crc    = crc8_byte(st_ff[3].crc, st_ff[3].status);
      vld_in          = adv ? {vld_ff[NSTAGE-2:0], issue} : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      blk_ff   <= blk_in;
      phase_ff <= phase_in;
      prev_ff  <= prev_in;
      if (adv) begin
         for (int k = 0; k < NSTAGE; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign rsp_valid           = vld_ff[NSTAGE-1];
   assign rsp_blk_num         = st_ff[NSTAGE-1].blk;
   assign rsp_payload         = {sync_pattern, st_ff[NSTAGE-1].fid, st_ff[NSTAGE-1].blk,
                                 st_ff[NSTAGE-1].status, st_ff[NSTAGE-1].crc};
   assign rsp_status_snapshot = st_ff[NSTAGE-1].status;
   assign rsp_bar_x_new       = st_ff[NSTAGE-1].x_new;
   assign rsp_bar_x_old       = st_ff[NSTAGE-1].x_old;
   assign rsp_last_block      = st_ff[NSTAGE-1].last;

endmodule

`default_nettype wire

[src/frame_tag_payload_generator.sv]
// Frame tag payload generator: a measurement gives no result.
// A frame gives BLOCK_COUNT results from a five-stage CRC pipeline, one per cycle
// while rsp_ready does not stall the output. A frame passes through the queue and
// the back end's frame registers before the CRC stages. A four-entry queue lets
// frames and measurements keep arriving while results drain. Synchronous reset clears
// the fault latch, sets the worst margin to 127, loads register defaults, empties stages.
`default_nettype none

module frame_tag_payload_generator
   import ftpg_pkg::*;
#(
   parameter int BLOCK_COUNT = 40
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_operation,
   input  wire logic [FID_W-1:0]   req_frame_id,
   input  wire logic [PHASE_W-1:0] req_bar_phase,
   input  wire logic [PHASE_W-1:0] req_prev_bar_phase,
   input  wire logic [7:0]         req_line_start,
   input  wire logic [7:0]         req_line_end,
   input  wire logic [15:0]        req_elapsed_ticks,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [BLK_W-1:0]        rsp_blk_num,
   output logic [53:0]             rsp_payload,
   output logic [7:0]              rsp_status_snapshot,
   output logic [7:0]              rsp_bar_x_new,
   output logic [7:0]              rsp_bar_x_old,
   output logic                    rsp_last_block,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   logic [7:0]  last_line_ff;
   logic [15:0] tick_budget_ff;
   logic [7:0]  sync_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;
   limits_type  limits;
   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;
   frame_type   q_wdata;
   frame_type   q_rdata;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_line_ff   <= LAST_LINE_RST;
         tick_budget_ff <= TICK_BUDGET_RST;
         sync_ff        <= SYNC_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_LAST_LINE:   last_line_ff   <= csr_pwdata[7:0];
            CSR_TICK_BUDGET: tick_budget_ff <= csr_pwdata[15:0];
            CSR_SYNC:        sync_ff        <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_LAST_LINE:   csr_prdata = {24'd0, last_line_ff};
         CSR_TICK_BUDGET: csr_prdata = {16'd0, tick_budget_ff};
         CSR_SYNC:        csr_prdata = {24'd0, sync_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign limits.last_line   = last_line_ff;
   assign limits.tick_budget = tick_budget_ff;

   ftpg_front u_front (
      .clock              (clock),
      .reset              (reset),
      .limits             (limits),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_frame_id       (req_frame_id),
      .req_bar_phase      (req_bar_phase),
      .req_prev_bar_phase (req_prev_bar_phase),
      .req_line_start     (req_line_start),
      .req_line_end       (req_line_end),
      .req_elapsed_ticks  (req_elapsed_ticks),
      .q_push             (q_push),
      .q_data             (q_wdata),
      .q_full             (q_full)
   );

   ftpg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   ftpg_back #(
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .sync_pattern        (sync_ff),
      .q_empty             (q_empty),
      .q_data              (q_rdata),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_blk_num         (rsp_blk_num),
      .rsp_payload         (rsp_payload),
      .rsp_status_snapshot (rsp_status_snapshot),
      .rsp_bar_x_new       (rsp_bar_x_new),
      .rsp_bar_x_old       (rsp_bar_x_old),
      .rsp_last_block      (rsp_last_block)
   );

endmodule

`default_nettype wire
